// ----- sv/txcon_pkg.sv -----
// Shared types and constants for the text console character writer.
// Holds the item structs, character codes, register indexes and the
// controller/datapath command and status bundles. No dependencies.
package txcon_pkg;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  char_code;
    logic [12:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [12:0] cursor_offset;
    logic [6:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic [15:0] read_value;
    logic        scrolled;
  } out_item_t;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_PRINT_MAX = 8'h7F;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd2;

  localparam logic [7:0] ATTR_RESET = 8'd15;
  localparam logic [6:0] ROWS_RESET = 7'd25;
  localparam logic [7:0] COLS_RESET = 8'd80;

  typedef struct packed {
    logic latch_in;   // capture the accepted input beat
    logic calc;       // decode the byte, move the cursor
    logic addr;       // form the cell address of the pending write
    logic cell_we;    // write the pending cell
    logic cp_start;   // reset the sweep counters
    logic cp_step;    // one step of the scroll copy
    logic zero_we;    // zero one cell and advance the sweep
    logic rd_cell;    // read the requested cell
    logic load_out;   // load the result register
  } txcon_cmd_t;

  typedef struct packed {
    logic is_read;
    logic need_scroll;
    logic rows_one;
    logic cp_last;
    logic blank_last;
    logic clr_last;
  } txcon_status_t;

endpackage

// ----- sv/txcon_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module txcon_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/txcon_datapath.sv -----
// Datapath of the console writer: configuration registers, cursor, byte
// decode, shared address multiplier, sweep counters and the screen RAM.
// Depends on txcon_pkg and txcon_ram.
module txcon_datapath #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [txcon_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                         cfg_data,
  input  txcon_pkg::in_item_t                in_data,
  input  txcon_pkg::txcon_cmd_t              cmd,
  output txcon_pkg::txcon_status_t           status,
  output txcon_pkg::out_item_t               out_data
);

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CT    = CW + 1;
  localparam int RT    = RW + 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = RW + CT + 1;

  // configuration
  logic [7:0] attr_r;
  logic [6:0] row_count_r;
  logic [7:0] col_count_r;
  logic [CT-1:0] cols_r, cols_nxt;
  logic [RT-1:0] rows_r, rows_nxt;

  // item and cursor
  logic          req_r;
  logic [7:0]    ch_r;
  logic [12:0]   idx_r;
  logic [CW-1:0] cur_col_r;
  logic [RW-1:0] cur_row_r;
  logic          scroll_r;

  // pending cell write
  logic [RW-1:0] wr_row_r;
  logic [CW-1:0] wr_col_r;
  logic          wr_we_r;
  logic [15:0]   wr_data_r;
  logic [AW-1:0] addr_r;

  // sweep counters for clear, scroll copy and blank row
  logic [AW-1:0] cp_addr_r;
  logic [CW-1:0] cp_col_r;
  logic [RW-1:0] cp_row_r;
  logic          wb_valid_r;
  logic [AW-1:0] wb_addr_r;

  logic [CW-1:0] col_e;
  logic [RW-1:0] row_e;
  logic [CT-1:0] col_n;
  logic [RT-1:0] row_n;
  logic          scroll_n;
  logic          we_n;
  logic [15:0]   wdat_n;
  logic [RW-1:0] wrow_n;
  logic [CW-1:0] wcol_n;

  logic [RW-1:0] mul_row;
  logic [CW-1:0] mul_col;
  logic [PW-1:0] prod;

  logic          col_end;
  logic          in_range;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= txcon_pkg::ATTR_RESET;
      row_count_r <= txcon_pkg::ROWS_RESET;
      col_count_r <= txcon_pkg::COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        txcon_pkg::REG_ATTR: attr_r      <= cfg_data;
        txcon_pkg::REG_ROWS: row_count_r <= cfg_data[6:0];
        txcon_pkg::REG_COLS: col_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // counts in use: zero reads as one, large values saturate
  always_comb begin
    if (col_count_r == 8'd0) begin
      cols_nxt = CT'(1);
    end else if (int'(col_count_r) > MAX_COLUMNS) begin
      cols_nxt = CT'(MAX_COLUMNS);
    end else begin
      cols_nxt = CT'(col_count_r);
    end
    if (row_count_r == 7'd0) begin
      rows_nxt = RT'(1);
    end else if (int'(row_count_r) > MAX_ROWS) begin
      rows_nxt = RT'(MAX_ROWS);
    end else begin
      rows_nxt = RT'(row_count_r);
    end
  end

  always_ff @(posedge clk) begin
    cols_r <= cols_nxt;
    rows_r <= rows_nxt;
  end

  // cursor clamped into the current screen
  assign col_e = ({1'b0, cur_col_r} >= cols_r) ? CW'(cols_r - CT'(1)) : cur_col_r;
  assign row_e = ({1'b0, cur_row_r} >= rows_r) ? RW'(rows_r - RT'(1)) : cur_row_r;

  always_comb begin
    col_n  = {1'b0, col_e};
    row_n  = {1'b0, row_e};
    we_n   = 1'b0;
    wdat_n = {attr_r, 8'h00};
    wrow_n = row_e;
    wcol_n = col_e;
    case (ch_r)
      txcon_pkg::CH_BS: begin
        if (col_e != '0) begin
          col_n  = col_n - CT'(1);
          wcol_n = col_e - CW'(1);
          we_n   = 1'b1;
        end else if (row_e != '0) begin
          row_n  = row_n - RT'(1);
          col_n  = cols_r - CT'(1);
          wrow_n = row_e - RW'(1);
          wcol_n = CW'(cols_r - CT'(1));
          we_n   = 1'b1;
        end
      end
      txcon_pkg::CH_TAB: col_n = (col_n + CT'(8)) & ~CT'(7);
      txcon_pkg::CH_CR:  col_n = '0;
      txcon_pkg::CH_LF: begin
        col_n = '0;
        row_n = row_n + RT'(1);
      end
      default: begin
        if (ch_r >= txcon_pkg::CH_SPACE && ch_r <= txcon_pkg::CH_PRINT_MAX) begin
          we_n   = 1'b1;
          wdat_n = {attr_r, ch_r};
          col_n  = col_n + CT'(1);
        end
      end
    endcase
    if (col_n >= cols_r) begin
      col_n = '0;
      row_n = row_n + RT'(1);
    end
    scroll_n = (row_n >= rows_r);
    if (scroll_n) begin
      row_n = rows_r - RT'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else if (cmd.calc) begin
      cur_col_r <= CW'(col_n);
      cur_row_r <= RW'(row_n);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r    <= in_data.req_type;
      ch_r     <= in_data.char_code;
      idx_r    <= in_data.cell_index;
      scroll_r <= 1'b0;
    end else if (cmd.calc) begin
      scroll_r <= scroll_n;
    end
    if (cmd.calc) begin
      wr_row_r  <= wrow_n;
      wr_col_r  <= wcol_n;
      wr_we_r   <= we_n;
      wr_data_r <= wdat_n;
    end
    if (cmd.addr) begin
      addr_r <= AW'(prod);
    end
  end

  // one multiplier, shared between the cell address and the cursor offset
  assign mul_row = cmd.addr ? wr_row_r : cur_row_r;
  assign mul_col = cmd.addr ? wr_col_r : cur_col_r;
  assign prod    = PW'(mul_row) * PW'(cols_r) + PW'(mul_col);

  assign col_end = ({1'b0, cp_col_r} == cols_r - CT'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_addr_r  <= '0;
      cp_col_r   <= '0;
      cp_row_r   <= '0;
      wb_valid_r <= 1'b0;
    end else begin
      wb_valid_r <= cmd.cp_step;
      if (cmd.cp_start) begin
        cp_addr_r <= '0;
        cp_col_r  <= '0;
        cp_row_r  <= '0;
      end else if (cmd.cp_step || cmd.zero_we) begin
        cp_addr_r <= cp_addr_r + AW'(1);
        if (col_end) begin
          cp_col_r <= '0;
          cp_row_r <= cp_row_r + RW'(1);
        end else begin
          cp_col_r <= cp_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= cp_addr_r;
  end

  // write port: copy write-back first, then cell write, then zero fill
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cp_addr_r;
    ram_wdata = '0;
    if (wb_valid_r) begin
      ram_we    = 1'b1;
      ram_waddr = wb_addr_r;
      ram_wdata = ram_rdata;
    end else if (cmd.cell_we && wr_we_r) begin
      ram_we    = 1'b1;
      ram_waddr = addr_r;
      ram_wdata = wr_data_r;
    end else if (cmd.zero_we) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = cmd.cp_step | cmd.rd_cell;
  assign ram_raddr = cmd.cp_step ? (cp_addr_r + AW'(cols_r)) : AW'(idx_r);

  txcon_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_range = (int'(idx_r) < DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.cursor_offset <= 13'(prod);
      out_data.cursor_col    <= 7'(cur_col_r);
      out_data.cursor_row    <= 6'(cur_row_r);
      out_data.read_value    <= (req_r == txcon_pkg::REQ_READ && in_range) ? ram_rdata
                                                                           : 16'h0000;
      out_data.scrolled      <= scroll_r;
    end
  end

  assign status.is_read     = (req_r == txcon_pkg::REQ_READ);
  assign status.need_scroll = scroll_r;
  assign status.rows_one    = (rows_r == RT'(1));
  assign status.cp_last     = ({1'b0, cp_row_r} == rows_r - RT'(2)) && col_end;
  assign status.blank_last  = col_end;
  assign status.clr_last    = (cp_addr_r == AW'(DEPTH - 1));

endmodule

// ----- sv/txcon_ctrl.sv -----
// Controller of the console writer: sequences clear, decode, cell write,
// scroll copy, blank row and result hand-off. Depends on txcon_pkg.
module txcon_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  txcon_pkg::txcon_status_t status,
  output txcon_pkg::txcon_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_EXEC   = 9'b000000100,
    S_ADDR   = 9'b000001000,
    S_WRITE  = 9'b000010000,
    S_SCROLL = 9'b000100000,
    S_DRAIN  = 9'b001000000,
    S_BLANK  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.zero_we = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.is_read) begin
          cmd.rd_cell = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.calc  = 1'b1;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.cell_we = 1'b1;
        if (status.need_scroll) begin
          cmd.cp_start = 1'b1;
          state_nxt    = status.rows_one ? S_BLANK : S_SCROLL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCROLL: begin
        cmd.cp_step = 1'b1;
        if (status.cp_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_BLANK;  // last copy beat lands here
      S_BLANK: begin
        cmd.zero_we = 1'b1;
        if (status.blank_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/text_console_char_writer.sv -----
// Top level of the text console character writer: controller, datapath
// and the configuration port. Depends on txcon_pkg, txcon_ctrl, txcon_datapath.
//
//   port   dir  beat contents
//   in_    in   in_item_t  (put a byte or read one cell)
//   out_   out  out_item_t (cursor position, cell value, scroll flag)
//   cfg_   in   register index + 8-bit data, always ready
//
// Sequence: a read reads its cell; a put decodes the byte, forms the address
// and writes the cell, and on a scroll copies rows 1 to rows-1 up a row through
// the RAM read and write ports, drains the last copy write and blanks the
// bottom row; both then load the result. Reset: a clearing pass zeroes all
// MAX_ROWS*MAX_COLUMNS cells with in_ready low; configuration writes are taken
// meanwhile. Stalls: a new item is accepted while the previous result waits
// in the output register; the item then holds in its last step until out_ready.
module text_console_char_writer #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  txcon_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output txcon_pkg::out_item_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [txcon_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  txcon_pkg::txcon_cmd_t    cmd;
  txcon_pkg::txcon_status_t status;

  assign cfg_ready = 1'b1;

  txcon_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  txcon_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_accept_while_zeroing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.zero_we |-> !in_ready)
    else $error("input accepted during a zero sweep");

  a_copy_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cp_step |=> !cmd.zero_we && !cmd.cell_we)
    else $error("write port taken during copy write-back");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid || out_ready)
    else $error("pending result overwritten");

  a_item_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> cmd.calc || cmd.rd_cell)
    else $error("accepted item not started");
`endif

endmodule
